FILE: sv/lzfw_pkg.sv
// lzfw_pkg: shared types and constants for the LZ flag-bit window decompressor.
// No dependencies. Used by lzfw_addr_unit and lz_flagbit_window_decompressor_unit.
`default_nettype none

package lzfw_pkg;

   // decoder phase codes
   typedef logic [2:0] phase_type;
   localparam phase_type PH_HDR_LO   = 3'd0;
   localparam phase_type PH_HDR_HI   = 3'd1;
   localparam phase_type PH_FLAG     = 3'd2;
   localparam phase_type PH_LITERAL  = 3'd3;
   localparam phase_type PH_MATCH_LO = 3'd4;
   localparam phase_type PH_MATCH_HI = 3'd5;
   localparam phase_type PH_DONE     = 3'd6;

   // address unit operations
   typedef logic [0:0] addr_op_type;
   localparam addr_op_type OP_SUB = 1'b0;   // (a - b) modulo window
   localparam addr_op_type OP_INC = 1'b1;   // (a + 1) modulo window

   localparam int          DIST_W     = 12;
   localparam logic [4:0]  MATCH_BIAS = 5'd3;
   localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

endpackage

`default_nettype wire

FILE: sv/lzfw_history_ram.sv
// lzfw_history_ram: single-write, single-read history window with registered read.
// No package dependencies.
`default_nettype none

module lzfw_history_ram #(
   parameter int DEPTH = 8192,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [7:0]    rd_data_ff
);

   logic [7:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: sv/lzfw_addr_unit.sv
// lzfw_addr_unit: shared modular address adder for the history window.
// Depends on lzfw_pkg for operation codes.
`default_nettype none

module lzfw_addr_unit #(
   parameter int WINDOW_SIZE = 8192,
   localparam int AW = $clog2(WINDOW_SIZE)
) (
   input  wire lzfw_pkg::addr_op_type op,
   input  wire logic [AW-1:0]         a,
   input  wire logic [AW-1:0]         b,
   output logic      [AW-1:0]         result
);
   import lzfw_pkg::*;

   localparam logic [AW:0] WIN = (AW+1)'(WINDOW_SIZE);

   logic [AW:0] diff;
   logic [AW:0] diff_fix;
   logic [AW:0] inc;

   always_comb begin
      diff     = {1'b0, a} - {1'b0, b};
      // borrow out means the source fell behind the window start
      diff_fix = diff[AW] ? (diff + WIN) : diff;
      inc      = {1'b0, a} + {{AW{1'b0}}, 1'b1};
      unique case (op)
         OP_SUB:  result = diff_fix[AW-1:0];
         OP_INC:  result = (inc == WIN) ? '0 : inc[AW-1:0];
         default: result = '0;
      endcase
   end

endmodule

`default_nettype wire

FILE: sv/lz_flagbit_window_decompressor_unit.sv
// Channel   Dir  Payload                                   Handshake
// req_      in   tdata[7:0]=comp_byte, tuser=stream_start  tvalid/tready
// rsp_      out  tdata[7:0]=data_byte, tlast=last_of_run,  tvalid/tready
//                tuser=stream_end
// Header, flag and match-low bytes are only consumed. A literal is accepted,
// then emitted. A match is accepted, then every copied byte needs a read on
// the history RAM's registered port, then an emit, before the next byte.
// req_tready is high only while no transaction is in progress; a stalled
// result holds the sequencer. Reset is synchronous; no clearing pass is run:
// unwritten window entries are tracked by the write pointer and a wrap flag
// and read as zero. Depends on lzfw_pkg, lzfw_addr_unit, lzfw_history_ram.
`default_nettype none

module lz_flagbit_window_decompressor_unit #(
   parameter int WINDOW_SIZE = 8192
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,    // [7:0] comp_byte
   input  wire logic       req_tuser,    // [0] stream_start
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic      [7:0] rsp_tdata,    // [7:0] data_byte
   output logic            rsp_tlast,
   output logic            rsp_tuser     // [0] stream_end
);
   import lzfw_pkg::*;

   localparam int AW = $clog2(WINDOW_SIZE);
   localparam logic [AW-1:0] PTR_LAST = AW'(WINDOW_SIZE - 1);

   localparam logic [1:0] SEQ_IDLE = 2'd0;
   localparam logic [1:0] SEQ_READ = 2'd1;
   localparam logic [1:0] SEQ_EMIT = 2'd2;

   logic [1:0]    seq_ff,   seq_in;
   phase_type     phase_ff, phase_in;
   logic [7:0]    flags_ff, flags_in;
   logic [3:0]    bits_ff,  bits_in;
   logic [15:0]   cons_ff,  cons_in;
   logic [15:0]   plen_ff,  plen_in;
   logic [7:0]    mlow_ff,  mlow_in;
   logic [AW-1:0] ptr_ff,   ptr_in;
   logic          wrap_ff,  wrap_in;
   logic [AW-1:0] src_ff,   src_in;
   logic [4:0]    left_ff,  left_in;
   logic          endf_ff,  endf_in;
   logic          copy_ff,  copy_in;
   logic [7:0]    lit_ff,   lit_in;
   logic          rvalid_ff, rvalid_in;

   logic          req_acc, rsp_acc;
   phase_type     ph;
   logic [7:0]    flags_b;
   logic [3:0]    bits_b;
   logic [15:0]   cons_b, cons_inc;
   logic [AW-1:0] ptr_b;
   logic          wrap_b;

   // token boundary
   logic [15:0]   bt_cons, bt_plen;
   logic [3:0]    bt_bits_dec;
   phase_type     bt_phase;
   logic [7:0]    bt_flags;
   logic [3:0]    bt_bits;

   addr_op_type   au_op;
   logic [AW-1:0] au_a, au_b, au_res;
   logic [7:0]    rd_data;
   logic [7:0]    out_byte;
   logic          last_byte;

   lzfw_addr_unit #(.WINDOW_SIZE(WINDOW_SIZE)) u_addr (
      .op     (au_op),
      .a      (au_a),
      .b      (au_b),
      .result (au_res)
   );

   lzfw_history_ram #(.DEPTH(WINDOW_SIZE)) u_hist (
      .clock      (clock),
      .wr_en      (rsp_acc),
      .wr_addr    (ptr_ff),
      .wr_data    (out_byte),
      .rd_en      (seq_ff == SEQ_READ),
      .rd_addr    (src_ff),
      .rd_data_ff (rd_data)
   );

   assign req_tready = (seq_ff == SEQ_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tvalid = (seq_ff == SEQ_EMIT);
   assign rsp_acc    = rsp_tvalid && rsp_tready;

   assign out_byte  = copy_ff ? (rvalid_ff ? rd_data : 8'h00) : lit_ff;
   assign last_byte = copy_ff ? (left_ff == 5'd1) : 1'b1;
   assign rsp_tdata = out_byte;
   assign rsp_tlast = last_byte;
   assign rsp_tuser = last_byte && endf_ff;

   // shared address unit: match source on accept, source increment while copying
   always_comb begin
      au_op = (seq_ff == SEQ_IDLE) ? OP_SUB : OP_INC;
      au_a  = (seq_ff == SEQ_IDLE) ? ptr_b : src_ff;
      au_b  = AW'({req_tdata, mlow_ff[7:4]});
   end

   always_comb begin
      ph       = req_tuser ? PH_HDR_LO : phase_ff;
      flags_b  = req_tuser ? 8'h00 : flags_ff;
      bits_b   = req_tuser ? 4'd1 : bits_ff;
      cons_b   = req_tuser ? 16'h0000 : cons_ff;
      ptr_b    = req_tuser ? '0 : ptr_ff;
      wrap_b   = req_tuser ? 1'b0 : wrap_ff;
      cons_inc = (cons_b == COUNT_MAX) ? cons_b : cons_b + 16'd1;

      bt_cons = (ph == PH_HDR_HI) ? 16'h0000 : cons_inc;
      bt_plen = (ph == PH_HDR_HI) ? {req_tdata, plen_ff[7:0]} : plen_ff;
      bt_bits_dec = bits_b - 4'd1;
      priority if (bt_cons >= bt_plen) begin
         bt_phase = PH_DONE;
         bt_flags = flags_b;
         bt_bits  = bits_b;
      end else if (bt_bits_dec == 4'd0) begin
         bt_phase = PH_FLAG;
         bt_flags = flags_b;
         bt_bits  = bt_bits_dec;
      end else begin
         bt_phase = flags_b[0] ? PH_LITERAL : PH_MATCH_LO;
         bt_flags = {1'b0, flags_b[7:1]};
         bt_bits  = bt_bits_dec;
      end
   end

   always_comb begin
      seq_in    = seq_ff;
      phase_in  = phase_ff;
      flags_in  = flags_ff;
      bits_in   = bits_ff;
      cons_in   = cons_ff;
      plen_in   = plen_ff;
      mlow_in   = mlow_ff;
      ptr_in    = ptr_ff;
      wrap_in   = wrap_ff;
      src_in    = src_ff;
      left_in   = left_ff;
      endf_in   = endf_ff;
      copy_in   = copy_ff;
      lit_in    = lit_ff;
      rvalid_in = rvalid_ff;

      unique case (seq_ff)
         SEQ_IDLE: begin
            if (req_acc) begin
               flags_in = flags_b;
               bits_in  = bits_b;
               cons_in  = cons_b;
               ptr_in   = ptr_b;
               wrap_in  = wrap_b;
               unique case (ph)
                  PH_HDR_LO: begin
                     plen_in  = {8'h00, req_tdata};
                     phase_in = PH_HDR_HI;
                  end
                  PH_HDR_HI: begin
                     plen_in  = bt_plen;
                     cons_in  = 16'h0000;
                     phase_in = bt_phase;
                     flags_in = bt_flags;
                     bits_in  = bt_bits;
                  end
                  PH_FLAG: begin
                     cons_in  = cons_inc;
                     flags_in = {1'b0, req_tdata[7:1]};
                     bits_in  = 4'd8;
                     phase_in = req_tdata[0] ? PH_LITERAL : PH_MATCH_LO;
                  end
                  PH_LITERAL: begin
                     cons_in  = cons_inc;
                     phase_in = bt_phase;
                     flags_in = bt_flags;
                     bits_in  = bt_bits;
                     endf_in  = (bt_phase == PH_DONE);
                     copy_in  = 1'b0;
                     lit_in   = req_tdata;
                     seq_in   = SEQ_EMIT;
                  end
                  PH_MATCH_LO: begin
                     cons_in  = cons_inc;
                     mlow_in  = req_tdata;
                     phase_in = PH_MATCH_HI;
                  end
                  PH_MATCH_HI: begin
                     cons_in  = cons_inc;
                     phase_in = bt_phase;
                     flags_in = bt_flags;
                     bits_in  = bt_bits;
                     endf_in  = (bt_phase == PH_DONE);
                     copy_in  = 1'b1;
                     src_in   = au_res;
                     left_in  = {1'b0, mlow_ff[3:0]} + MATCH_BIAS;
                     seq_in   = SEQ_READ;
                  end
                  default: begin
                     // after the end: byte dropped until the next stream start
                  end
               endcase
            end
         end
         SEQ_READ: begin
            // entry holds a written byte if the window has wrapped or it lies behind ptr
            rvalid_in = wrap_ff || (src_ff < ptr_ff);
            seq_in    = SEQ_EMIT;
         end
         SEQ_EMIT: begin
            if (rsp_acc) begin
               ptr_in  = (ptr_ff == PTR_LAST) ? '0 : ptr_ff + AW'(1);
               wrap_in = wrap_ff || (ptr_ff == PTR_LAST);
               src_in  = au_res;
               left_in = copy_ff ? left_ff - 5'd1 : left_ff;
               seq_in  = last_byte ? SEQ_IDLE : SEQ_READ;
            end
         end
         default: seq_in = SEQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff   <= SEQ_IDLE;
         phase_ff <= PH_HDR_LO;
         flags_ff <= 8'h00;
         bits_ff  <= 4'd1;
         cons_ff  <= 16'h0000;
         plen_ff  <= 16'h0000;
         mlow_ff  <= 8'h00;
         ptr_ff   <= '0;
         wrap_ff  <= 1'b0;
         left_ff  <= 5'd0;
         copy_ff  <= 1'b0;
      end else begin
         seq_ff   <= seq_in;
         phase_ff <= phase_in;
         flags_ff <= flags_in;
         bits_ff  <= bits_in;
         cons_ff  <= cons_in;
         plen_ff  <= plen_in;
         mlow_ff  <= mlow_in;
         ptr_ff   <= ptr_in;
         wrap_ff  <= wrap_in;
         left_ff  <= left_in;
         copy_ff  <= copy_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff    <= src_in;
      endf_ff   <= endf_in;
      lit_ff    <= lit_in;
      rvalid_ff <= rvalid_in;
   end

   // a copy in flight always has bytes left to move
   a_copy_left: assert property (@(posedge clock) disable iff (reset)
      (seq_ff == SEQ_READ) |-> (copy_ff && left_ff != 5'd0 && left_ff <= 5'd18))
      else $error("copy sequencer running with bad byte count");

   // stream end only marks the last byte of a transaction
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("stream end flagged on a non-final byte");

   // a read cycle is always followed by the emit cycle
   a_read_emit: assert property (@(posedge clock) disable iff (reset)
      (seq_ff == SEQ_READ) |=> (seq_ff == SEQ_EMIT))
      else $error("read data not presented");

   // once the stream has ended the decoder makes no more results
   a_done_quiet: assert property (@(posedge clock) disable iff (reset)
      req_acc && !req_tuser && phase_ff == PH_DONE |=> req_tready && phase_ff == PH_DONE)
      else $error("decoder left the end state without a stream start");

   // the write pointer moves only when a byte is delivered or a stream start resets it
   a_ptr_move: assert property (@(posedge clock) disable iff (reset)
      !rsp_acc && !(req_acc && req_tuser) |=> $stable(ptr_ff))
      else $error("write pointer moved without a delivered byte");

endmodule

`default_nettype wire
